// File: src/mmix_pkg.sv
package mmix_pkg;

  localparam int FRAC_BITS = 14;

  localparam int THR_W = 15;
  localparam int CMD_W = 16;
  localparam int GAIN_W = 15;
  localparam int PULSE_W = 12;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int PROD_W = GAIN_W + CMD_W + 1;
  localparam int RATE_W = PROD_W - FRAC_BITS;
  localparam int AX_W = (RATE_W > CMD_W) ? RATE_W : CMD_W;
  localparam int VAL_W = AX_W + 4;
  localparam int SPAN_W = PULSE_W + 1;
  localparam int SCALED_W = SPAN_W + VAL_W;

  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int LOW_THROTTLE = (ONE_Q + 99) / 100;
  localparam int PULSE_TOP = (1 << PULSE_W) - 1;
  localparam logic [PULSE_W-1:0] IDLE_PULSE = PULSE_W'(1000);

  localparam int MOTORS = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    REG_PULSE_MIN  = 3'd0,
    REG_PULSE_MAX  = 3'd1,
    REG_ROLL_GAIN  = 3'd2,
    REG_PITCH_GAIN = 3'd3,
    REG_YAW_GAIN   = 3'd4,
    REG_HEX_FRAME  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_HEX,
    KIND_QUAD_HOLD,
    KIND_QUAD_MIX
  } kind_t;

  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic signed [AX_W-1:0] axis_t;

  typedef struct packed {
    pulse_t pulse_min;
    pulse_t pulse_max;
    gain_t  roll_gain;
    gain_t  pitch_gain;
    gain_t  yaw_gain;
    logic   hex_frame;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [THR_W-1:0]  throttle;
    axis_t             roll;
    axis_t             pitch;
    axis_t             yaw;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: src/mmix_regs.sv
module mmix_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mmix_pkg::ADDR_W-1:0]   paddr,
  input  logic [mmix_pkg::DATA_W-1:0]   pwdata,
  output logic [mmix_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mmix_pkg::cfg_t                cfg
);
  import mmix_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_min  <= PULSE_W'(1000);
      cfg.pulse_max  <= PULSE_W'(2000);
      cfg.roll_gain  <= GAIN_W'(ONE_Q);
      cfg.pitch_gain <= GAIN_W'(ONE_Q);
      cfg.yaw_gain   <= GAIN_W'(ONE_Q);
      cfg.hex_frame  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PULSE_MIN:  cfg.pulse_min  <= pwdata[PULSE_W-1:0];
        REG_PULSE_MAX:  cfg.pulse_max  <= pwdata[PULSE_W-1:0];
        REG_ROLL_GAIN:  cfg.roll_gain  <= pwdata[GAIN_W-1:0];
        REG_PITCH_GAIN: cfg.pitch_gain <= pwdata[GAIN_W-1:0];
        REG_YAW_GAIN:   cfg.yaw_gain   <= pwdata[GAIN_W-1:0];
        REG_HEX_FRAME:  cfg.hex_frame  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PULSE_MIN:  prdata = DATA_W'(cfg.pulse_min);
      REG_PULSE_MAX:  prdata = DATA_W'(cfg.pulse_max);
      REG_ROLL_GAIN:  prdata = DATA_W'(cfg.roll_gain);
      REG_PITCH_GAIN: prdata = DATA_W'(cfg.pitch_gain);
      REG_YAW_GAIN:   prdata = DATA_W'(cfg.yaw_gain);
      REG_HEX_FRAME:  prdata = DATA_W'(cfg.hex_frame);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: src/mmix_front.sv
module mmix_front (
  input  logic                         clk,
  input  logic                         rst,
  input  mmix_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mmix_pkg::THR_W-1:0]   throttle,
  input  logic signed [mmix_pkg::CMD_W-1:0] roll_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] pitch_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] yaw_cmd,
  input  logic                         armed,
  input  logic                         queue_full,
  output logic                         job_valid,
  output mmix_pkg::job_t               job
);
  import mmix_pkg::*;

  logic signed [PROD_W-1:0] roll_prod;
  logic signed [PROD_W-1:0] pitch_prod;
  logic signed [PROD_W-1:0] yaw_prod;
  job_t                     job_next;
  logic                     load;

  assign roll_prod  = $signed({1'b0, cfg.roll_gain}) * roll_cmd;
  assign pitch_prod = $signed({1'b0, cfg.pitch_gain}) * pitch_cmd;
  assign yaw_prod   = $signed({1'b0, cfg.yaw_gain}) * yaw_cmd;

  always_comb begin
    job_next.throttle = throttle;
    priority if (!armed) begin
      job_next.kind = KIND_IDLE;
    end else if (cfg.hex_frame) begin
      job_next.kind = KIND_HEX;
    end else if (throttle < THR_W'(LOW_THROTTLE)) begin
      job_next.kind = KIND_QUAD_HOLD;
    end else begin
      job_next.kind = KIND_QUAD_MIX;
    end
    if (cfg.hex_frame) begin
      job_next.roll  = AX_W'(roll_cmd);
      job_next.pitch = AX_W'(pitch_cmd);
      job_next.yaw   = AX_W'(yaw_cmd);
    end else begin
      job_next.roll  = AX_W'($signed(roll_prod[PROD_W-1:FRAC_BITS]));
      job_next.pitch = AX_W'($signed(pitch_prod[PROD_W-1:FRAC_BITS]));
      job_next.yaw   = AX_W'($signed(yaw_prod[PROD_W-1:FRAC_BITS]));
    end
  end

  assign in_stall = job_valid && queue_full;
  assign load = !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (load) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      job <= job_next;
    end
  end

endmodule

// File: src/mmix_queue.sv
module mmix_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mmix_pkg::job_t          push_job,
  input  logic                    pop,
  output mmix_pkg::job_t          pop_job,
  output mmix_pkg::queue_status_t status
);
  import mmix_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push_en;
  logic                pop_en;

  assign status.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign push_en = push && !status.full;
  assign pop_en  = pop && !status.empty;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push_en, pop_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// File: src/mmix_back.sv
module mmix_back (
  input  logic                    clk,
  input  logic                    rst,
  input  mmix_pkg::cfg_t          cfg,
  input  mmix_pkg::queue_status_t q_status,
  input  mmix_pkg::job_t          q_job,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output mmix_pkg::pulse_t [mmix_pkg::MOTORS-1:0] motor,
  output logic                    outputs_enabled
);
  import mmix_pkg::*;

  localparam int PW = SCALED_W - FRAC_BITS;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [VAL_W:0] sum_t;
  typedef val_t [MOTORS-1:0] vals_t;
  typedef logic signed [SCALED_W-1:0] scaled_t;

  typedef struct packed {
    kind_t kind;
    vals_t val;
    axis_t roll;
    axis_t yaw;
  } mix_stage_t;

  typedef struct packed {
    kind_t                      kind;
    scaled_t [MOTORS-1:0]       scaled;
  } map_stage_t;

  localparam sum_t ONE_S = sum_t'(ONE_Q);

  function automatic vals_t mix_axis(input vals_t m, input logic [2:0] a, input logic [2:0] b,
                                     input logic [2:0] c, input logic [2:0] d,
                                     input axis_t rate);
    vals_t res;
    sum_t  rx;
    sum_t  sa;
    sum_t  sb;
    sum_t  sc;
    sum_t  sd;
    res = m;
    rx = sum_t'(rate);
    sa = sum_t'(m[a]) + rx;
    sb = sum_t'(m[b]) + rx;
    sc = sum_t'(m[c]) - rx;
    sd = sum_t'(m[d]) - rx;
    if (!rate[AX_W-1]) begin
      if (sa > ONE_S || sb > ONE_S) begin
        res[c] = val_t'(sc);
        res[d] = val_t'(sd);
      end else begin
        res[a] = val_t'(sa);
        res[b] = val_t'(sb);
      end
    end else begin
      if (sc > ONE_S || sd > ONE_S) begin
        res[a] = val_t'(sa);
        res[b] = val_t'(sb);
      end else begin
        res[c] = val_t'(sc);
        res[d] = val_t'(sd);
      end
    end
    return res;
  endfunction

  function automatic pulse_t saturate(input logic signed [PW-1:0] p);
    pulse_t res;
    if (p < 0) begin
      res = '0;
    end else if (p > PW'(PULSE_TOP)) begin
      res = PULSE_W'(PULSE_TOP);
    end else begin
      res = p[PULSE_W-1:0];
    end
    return res;
  endfunction

  logic       adv;
  logic       s1_valid;
  logic       s2_valid;
  logic       s3_valid;
  logic       s4_valid;
  mix_stage_t s1;
  mix_stage_t s2;
  mix_stage_t s3;
  map_stage_t s4;
  mix_stage_t s1_next;
  mix_stage_t s2_next;
  mix_stage_t s3_next;
  map_stage_t s4_next;
  pulse_t [MOTORS-1:0] motor_next;
  logic signed [SPAN_W-1:0] span;
  val_t tv;
  val_t rv;
  val_t pv;
  val_t yv;
  val_t tp;
  val_t tn;
  val_t t2;
  val_t y2;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_status.empty;

  always_comb begin
    tv = val_t'($signed({1'b0, q_job.throttle}));
    rv = val_t'(q_job.roll);
    pv = val_t'(q_job.pitch);
    yv = val_t'(q_job.yaw);
    t2 = tv <<< 1;
    y2 = yv <<< 1;
    tp = t2 + (pv <<< 1);
    tn = t2 - (pv <<< 1);
    s1_next.kind = q_job.kind;
    s1_next.roll = q_job.roll;
    s1_next.yaw  = q_job.yaw;
    s1_next.val  = '0;
    if (q_job.kind == KIND_HEX) begin
      s1_next.val[0] = tp + rv + y2;
      s1_next.val[1] = tp - rv - y2;
      s1_next.val[2] = t2 + (rv <<< 1) - y2;
      s1_next.val[3] = t2 - (rv <<< 1) + y2;
      s1_next.val[4] = tn + rv + y2;
      s1_next.val[5] = tn - rv - y2;
    end else begin
      for (int i = 0; i < 4; i++) begin
        s1_next.val[i] = tv;
      end
      if (q_job.kind == KIND_QUAD_MIX) begin
        s1_next.val = mix_axis(s1_next.val, 3'd0, 3'd1, 3'd2, 3'd3, q_job.pitch);
      end
    end
  end

  always_comb begin
    s2_next = s1;
    if (s1.kind == KIND_QUAD_MIX) begin
      s2_next.val = mix_axis(s1.val, 3'd0, 3'd2, 3'd1, 3'd3, s1.roll);
    end
  end

  always_comb begin
    s3_next = s2;
    if (s2.kind == KIND_QUAD_MIX) begin
      s3_next.val = mix_axis(s2.val, 3'd1, 3'd2, 3'd0, 3'd3, s2.yaw);
    end
  end

  assign span = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});

  always_comb begin
    s4_next.kind = s3.kind;
    for (int i = 0; i < MOTORS; i++) begin
      if (s3.kind == KIND_HEX) begin
        s4_next.scaled[i] = span * s3.val[i];
      end else begin
        s4_next.scaled[i] = span * (s3.val[i] <<< 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      motor_next[i] = saturate(PW'($signed(s4.scaled[i][SCALED_W-1:FRAC_BITS+1]))
                               + PW'($signed({1'b0, cfg.pulse_min})));
      if (s4.kind == KIND_IDLE) begin
        motor_next[i] = IDLE_PULSE;
      end else if (s4.kind != KIND_HEX && i >= 4) begin
        motor_next[i] = IDLE_PULSE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1              <= s1_next;
      s2              <= s2_next;
      s3              <= s3_next;
      s4              <= s4_next;
      motor           <= motor_next;
      outputs_enabled <= (s4.kind != KIND_IDLE);
    end
  end

endmodule

// File: src/multirotor_motor_mixer.sv
// Motor mixer for four and six motor frames. Each transaction on the input
// channel is one command set, and each yields exactly one transaction of six
// pulse widths on the output channel, in order. One command set is taken per
// clock cycle while in_stall is low. A set is loaded into the front register
// at the accepting edge, then into one entry of the four entry queue, then
// through five back stages (s1 to s4 and the output register). There is one
// scaling multiplier per motor, so the steady rate is one set per cycle while
// the output is not stalled. The queue keeps taking input while the output is
// stalled until it holds four sets.
// Registers may be written only while no transaction is in flight.
module multirotor_motor_mixer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mmix_pkg::ADDR_W-1:0]  paddr,
  input  logic [mmix_pkg::DATA_W-1:0]  pwdata,
  output logic [mmix_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mmix_pkg::THR_W-1:0]   throttle,
  input  logic signed [mmix_pkg::CMD_W-1:0] roll_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] pitch_cmd,
  input  logic signed [mmix_pkg::CMD_W-1:0] yaw_cmd,
  input  logic                         armed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mmix_pkg::PULSE_W-1:0] motor_zero,
  output logic [mmix_pkg::PULSE_W-1:0] motor_one,
  output logic [mmix_pkg::PULSE_W-1:0] motor_two,
  output logic [mmix_pkg::PULSE_W-1:0] motor_three,
  output logic [mmix_pkg::PULSE_W-1:0] motor_four,
  output logic [mmix_pkg::PULSE_W-1:0] motor_five,
  output logic                         outputs_enabled
);
  import mmix_pkg::*;

  cfg_t                cfg;
  logic                job_valid;
  job_t                job;
  job_t                q_job;
  queue_status_t       q_status;
  logic                pop;
  pulse_t [MOTORS-1:0] motor;

  mmix_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mmix_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .throttle   (throttle),
    .roll_cmd   (roll_cmd),
    .pitch_cmd  (pitch_cmd),
    .yaw_cmd    (yaw_cmd),
    .armed      (armed),
    .queue_full (q_status.full),
    .job_valid  (job_valid),
    .job        (job)
  );

  mmix_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_valid),
    .push_job (job),
    .pop      (pop),
    .pop_job  (q_job),
    .status   (q_status)
  );

  mmix_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_status        (q_status),
    .q_job           (q_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .motor           (motor),
    .outputs_enabled (outputs_enabled)
  );

  assign motor_zero  = motor[0];
  assign motor_one   = motor[1];
  assign motor_two   = motor[2];
  assign motor_three = motor[3];
  assign motor_four  = motor[4];
  assign motor_five  = motor[5];

  // A disarmed transaction drives every motor to the idle pulse.
  a_disarmed_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !outputs_enabled |->
      motor_zero == IDLE_PULSE && motor_one == IDLE_PULSE &&
      motor_two == IDLE_PULSE && motor_three == IDLE_PULSE &&
      motor_four == IDLE_PULSE && motor_five == IDLE_PULSE)
    else $error("disarmed transaction with a non-idle motor pulse");

  // The four motor frame never drives motors four and five.
  a_quad_spare_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cfg.hex_frame |->
      motor_four == IDLE_PULSE && motor_five == IDLE_PULSE)
    else $error("four motor frame drove a spare motor");

  // The input side stalls only while a set waits on a full queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> job_valid && q_status.full && !q_status.empty)
    else $error("input stalled without a full queue");

endmodule

// File: test/multirotor_motor_mixer_test.sv
`timescale 1ns / 100ps

module multirotor_motor_mixer_test;
  import mmix_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 100;
  localparam int EXTREME_ITEMS = 15;

  typedef struct packed {
    logic [THR_W-1:0] throttle;
    logic [CMD_W-1:0] roll;
    logic [CMD_W-1:0] pitch;
    logic [CMD_W-1:0] yaw;
    logic             armed;
  } cmd_set_t;

  typedef struct packed {
    logic [MOTORS-1:0][PULSE_W-1:0] motor;
    logic                           enabled;
  } motor_set_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic [THR_W-1:0] throttle;
  logic signed [CMD_W-1:0] roll_cmd;
  logic signed [CMD_W-1:0] pitch_cmd;
  logic signed [CMD_W-1:0] yaw_cmd;
  logic armed;
  logic out_valid;
  logic out_stall;
  logic [PULSE_W-1:0] motor_zero;
  logic [PULSE_W-1:0] motor_one;
  logic [PULSE_W-1:0] motor_two;
  logic [PULSE_W-1:0] motor_three;
  logic [PULSE_W-1:0] motor_four;
  logic [PULSE_W-1:0] motor_five;
  logic outputs_enabled;

  cfg_t mixer_cfg;
  longint quad_level [4];
  motor_set_t expected_pulses [$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  string motor_field [MOTORS] = '{"motor_zero", "motor_one", "motor_two",
                                  "motor_three", "motor_four", "motor_five"};

  multirotor_motor_mixer dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .throttle(throttle),
    .roll_cmd(roll_cmd),
    .pitch_cmd(pitch_cmd),
    .yaw_cmd(yaw_cmd),
    .armed(armed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .motor_zero(motor_zero),
    .motor_one(motor_one),
    .motor_two(motor_two),
    .motor_three(motor_three),
    .motor_four(motor_four),
    .motor_five(motor_five),
    .outputs_enabled(outputs_enabled)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_wait();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_width(longint level, int shift);
    longint span;
    longint width;
    span = longint'(mixer_cfg.pulse_max) - longint'(mixer_cfg.pulse_min);
    width = longint'(mixer_cfg.pulse_min) + ((span * level) >>> shift);
    if (width < 0) begin
      width = 0;
    end
    if (width > PULSE_TOP) begin
      width = PULSE_TOP;
    end
    return width[PULSE_W-1:0];
  endfunction

  // A rate raises one pair (a and b if non-negative, else c and d) unless
  // either would exceed full scale; then the opposite pair is lowered.
  function automatic void apply_axis(int a, int b, int c, int d, longint rate);
    if (rate >= 0) begin
      if (quad_level[a] + rate > ONE_Q || quad_level[b] + rate > ONE_Q) begin
        quad_level[c] = quad_level[c] - rate;
        quad_level[d] = quad_level[d] - rate;
      end else begin
        quad_level[a] = quad_level[a] + rate;
        quad_level[b] = quad_level[b] + rate;
      end
    end else begin
      if (quad_level[c] - rate > ONE_Q || quad_level[d] - rate > ONE_Q) begin
        quad_level[a] = quad_level[a] + rate;
        quad_level[b] = quad_level[b] + rate;
      end else begin
        quad_level[c] = quad_level[c] - rate;
        quad_level[d] = quad_level[d] - rate;
      end
    end
  endfunction

  function automatic motor_set_t mix_motors(cmd_set_t c);
    longint t;
    longint r;
    longint p;
    longint y;
    longint roll_adj;
    longint pitch_adj;
    longint yaw_adj;
    longint hex_level [MOTORS];
    motor_set_t e;
    int i;
    t = longint'(c.throttle);
    r = longint'($signed(c.roll));
    p = longint'($signed(c.pitch));
    y = longint'($signed(c.yaw));
    e.enabled = c.armed;
    if (!c.armed) begin
      for (i = 0; i < MOTORS; i++) begin
        e.motor[i] = IDLE_PULSE;
      end
      return e;
    end
    if (mixer_cfg.hex_frame) begin
      hex_level[0] = 2 * t + 2 * p + r + 2 * y;
      hex_level[1] = 2 * t + 2 * p - r - 2 * y;
      hex_level[2] = 2 * t + 2 * r - 2 * y;
      hex_level[3] = 2 * t - 2 * r + 2 * y;
      hex_level[4] = 2 * t - 2 * p + r + 2 * y;
      hex_level[5] = 2 * t - 2 * p - r - 2 * y;
      for (i = 0; i < MOTORS; i++) begin
        e.motor[i] = pulse_width(hex_level[i], FRAC_BITS + 1);
      end
    end else begin
      for (i = 0; i < 4; i++) begin
        quad_level[i] = t;
      end
      if (100 * t >= ONE_Q) begin
        roll_adj = (longint'(mixer_cfg.roll_gain) * r) >>> FRAC_BITS;
        pitch_adj = (longint'(mixer_cfg.pitch_gain) * p) >>> FRAC_BITS;
        yaw_adj = (longint'(mixer_cfg.yaw_gain) * y) >>> FRAC_BITS;
        apply_axis(0, 1, 2, 3, pitch_adj);
        apply_axis(0, 2, 1, 3, roll_adj);
        apply_axis(1, 2, 0, 3, yaw_adj);
      end
      for (i = 0; i < 4; i++) begin
        e.motor[i] = pulse_width(quad_level[i], FRAC_BITS);
      end
      e.motor[4] = IDLE_PULSE;
      e.motor[5] = IDLE_PULSE;
    end
    return e;
  endfunction

  function automatic cmd_set_t make_cmd(int thr, int r, int p, int y, bit arm);
    cmd_set_t c;
    c.throttle = thr[THR_W-1:0];
    c.roll = r[CMD_W-1:0];
    c.pitch = p[CMD_W-1:0];
    c.yaw = y[CMD_W-1:0];
    c.armed = arm;
    return c;
  endfunction

  function automatic logic [CMD_W-1:0] random_axis();
    int v;
    case ($urandom_range(0, 4))
      0, 1, 2: v = int'($urandom_range(0, 32768)) - 16384;
      3: v = int'($urandom_range(0, 4000)) - 2000;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return v[CMD_W-1:0];
  endfunction

  function automatic cmd_set_t random_cmd();
    cmd_set_t c;
    case ($urandom_range(0, 9))
      0: c.throttle = THR_W'($urandom_range(0, 300));
      1, 2: c.throttle = THR_W'($urandom_range(0, 32767));
      default: c.throttle = THR_W'($urandom_range(0, ONE_Q));
    endcase
    c.roll = random_axis();
    c.pitch = random_axis();
    c.yaw = random_axis();
    c.armed = ($urandom_range(0, 9) != 0);
    return c;
  endfunction

  function automatic int random_gain();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32767;
      2: return ONE_Q;
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  task automatic send_command(input cmd_set_t c);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    throttle <= c.throttle;
    roll_cmd <= c.roll;
    pitch_cmd <= c.pitch;
    yaw_cmd <= c.yaw;
    armed <= c.armed;
    do @(posedge clk); while (in_stall);
    expected_pulses.push_back(mix_motors(c));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pulses.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PULSE_MIN: mixer_cfg.pulse_min = value[PULSE_W-1:0];
      REG_PULSE_MAX: mixer_cfg.pulse_max = value[PULSE_W-1:0];
      REG_ROLL_GAIN: mixer_cfg.roll_gain = value[GAIN_W-1:0];
      REG_PITCH_GAIN: mixer_cfg.pitch_gain = value[GAIN_W-1:0];
      REG_YAW_GAIN: mixer_cfg.yaw_gain = value[GAIN_W-1:0];
      REG_HEX_FRAME: mixer_cfg.hex_frame = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_mixer(input int pmin, input int pmax, input int rg, input int pg,
                               input int yg, input bit hex);
    drain_pipeline();
    write_register(REG_PULSE_MIN, pmin);
    write_register(REG_PULSE_MAX, pmax);
    write_register(REG_ROLL_GAIN, rg);
    write_register(REG_PITCH_GAIN, pg);
    write_register(REG_YAW_GAIN, yg);
    write_register(REG_HEX_FRAME, DATA_W'(hex));
  endtask

  task automatic test_quad_directed();
    send_command(make_cmd(ONE_Q, 16384, -16384, 32767, 1'b0));
    send_command(make_cmd(0, 0, 0, 0, 1'b1));
    send_command(make_cmd(163, 8000, -8000, 8000, 1'b1));
    send_command(make_cmd(164, 8000, -8000, 8000, 1'b1));
    send_command(make_cmd(8192, -4096, 4096, 2048, 1'b1));
    send_command(make_cmd(ONE_Q, 0, 4096, 0, 1'b1));
    send_command(make_cmd(ONE_Q, 0, -4096, 0, 1'b1));
    send_command(make_cmd(ONE_Q, 16384, -16384, 16384, 1'b1));
    send_command(make_cmd(32767, -32768, 32767, -32768, 1'b1));
    send_command(make_cmd(1000, -16384, -16384, -16384, 1'b1));
    send_command(make_cmd(32767, 32767, 32767, 32767, 1'b0));
  endtask

  task automatic test_hex_directed();
    program_mixer(1000, 2000, ONE_Q, ONE_Q, ONE_Q, 1'b1);
    send_command(make_cmd(8192, 1, 0, 0, 1'b1));
    send_command(make_cmd(8192, -1, 3, -5, 1'b1));
    send_command(make_cmd(ONE_Q, 16384, 16384, 16384, 1'b1));
    send_command(make_cmd(0, -32768, -32768, -32768, 1'b1));
    send_command(make_cmd(100, 5000, -3000, 1000, 1'b1));
    send_command(make_cmd(32767, 32767, -32768, 32767, 1'b1));
    send_command(make_cmd(ONE_Q, 1, 1, 1, 1'b0));
  endtask

  task automatic test_register_extremes();
    int setting;
    int k;
    for (setting = 0; setting < 4; setting++) begin
      case (setting)
        0: program_mixer(4095, 0, 0, 0, 0, 1'b0);
        1: program_mixer(0, 4095, 32767, 32767, 32767, 1'b0);
        2: program_mixer(4095, 4095, 32767, 0, 32767, 1'b1);
        default: program_mixer(0, 0, 0, 32767, 0, 1'b1);
      endcase
      for (k = 0; k < EXTREME_ITEMS; k++) begin
        send_command(random_cmd());
      end
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int k;
    int pmin;
    int pmax;
    for (phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 4))
        0: begin
          pmin = 1000;
          pmax = 2000;
        end
        1: begin
          pmin = 0;
          pmax = 4095;
        end
        2: begin
          pmin = $urandom_range(0, 4095);
          pmax = pmin;
        end
        default: begin
          pmin = $urandom_range(0, 4095);
          pmax = $urandom_range(0, 4095);
        end
      endcase
      program_mixer(pmin, pmax, random_gain(), random_gain(), random_gain(),
                    1'($urandom_range(0, 1)));
      no_idle = (phase % 4 == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 5 && k == PHASE_ITEMS / 2) begin
          drain_pipeline();
        end
        send_command(random_cmd());
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    throttle = '0;
    roll_cmd = '0;
    pitch_cmd = '0;
    yaw_cmd = '0;
    armed = 1'b0;
    mixer_cfg.pulse_min = PULSE_W'(1000);
    mixer_cfg.pulse_max = PULSE_W'(2000);
    mixer_cfg.roll_gain = GAIN_W'(ONE_Q);
    mixer_cfg.pitch_gain = GAIN_W'(ONE_Q);
    mixer_cfg.yaw_gain = GAIN_W'(ONE_Q);
    mixer_cfg.hex_frame = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_quad_directed();
    test_hex_directed();
    test_register_extremes();
    test_random_traffic();
    drain_pipeline();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_pulses.size() == 0) begin
      $display("multirotor_motor_mixer_test: PASS");
    end else begin
      $display("multirotor_motor_mixer_test: FAIL");
    end
    $finish;
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      hold = draw_wait();
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    motor_set_t seen;
    motor_set_t want;
    int i;
    if (!rst && out_valid && !out_stall) begin
      seen.motor = {motor_five, motor_four, motor_three, motor_two, motor_one, motor_zero};
      seen.enabled = outputs_enabled;
      if (expected_pulses.size() == 0) begin
        $error("unexpected output transaction");
        error_count++;
      end else begin
        want = expected_pulses.pop_front();
        for (i = 0; i < MOTORS; i++) begin
          if (seen.motor[i] !== want.motor[i]) begin
            $error("%s: expected %0d, actual %0d", motor_field[i], want.motor[i],
                   seen.motor[i]);
            error_count++;
          end
        end
        if (seen.enabled !== want.enabled) begin
          $error("outputs_enabled: expected %0d, actual %0d", want.enabled, seen.enabled);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("multirotor_motor_mixer_test: FAIL");
        $finish;
      end
    end
  end

endmodule

// File: multirotor_motor_mixer.f
src/mmix_pkg.sv
src/mmix_regs.sv
src/mmix_front.sv
src/mmix_queue.sv
src/mmix_back.sv
src/multirotor_motor_mixer.sv
test/multirotor_motor_mixer_test.sv
